// ===== rtl/led_overlay_pulse_blink_controller_assert.svh =====
// Assertion macros for the RTL of the LED overlay controller, included by lopbc_ctrl.
`ifndef LED_OVERLAY_PULSE_BLINK_CONTROLLER_ASSERT_SVH
`define LED_OVERLAY_PULSE_BLINK_CONTROLLER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define LOPBC_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lopbc assertion failed");
`define LOPBC_ASSERT_RST(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("lopbc reset assertion failed");
`else
`define LOPBC_ASSERT(name, prop)
`define LOPBC_ASSERT_RST(name, prop)
`endif
`endif

// ===== rtl/lopbc_pkg.sv =====
`default_nettype none
package lopbc_pkg;

  localparam int NUM_LEDS    = 64;
  localparam int PULSE_SLOTS = 8;
  localparam int BLINK_SLOTS = 4;

  localparam int PIDX_W = (PULSE_SLOTS > 1) ? $clog2(PULSE_SLOTS) : 1;
  localparam int BIDX_W = (BLINK_SLOTS > 1) ? $clog2(BLINK_SLOTS) : 1;
  localparam int SLOT_W = (PIDX_W > BIDX_W) ? PIDX_W : BIDX_W;

  localparam logic [63:0] LED_ALL =
    (NUM_LEDS >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << NUM_LEDS) - 64'd1);

  localparam logic [3:0] OP_SET          = 4'd0;
  localparam logic [3:0] OP_SET_TEMP     = 4'd1;
  localparam logic [3:0] OP_TOGGLE       = 4'd2;
  localparam logic [3:0] OP_TOGGLE_TEMP  = 4'd3;
  localparam logic [3:0] OP_RESTORE      = 4'd4;
  localparam logic [3:0] OP_PULSE        = 4'd5;
  localparam logic [3:0] OP_BLINK_ON     = 4'd6;
  localparam logic [3:0] OP_BLINK_OFF    = 4'd7;
  localparam logic [3:0] OP_CLEAR_BLINKS = 4'd8;
  localparam logic [3:0] OP_CLEAR_ALL    = 4'd9;
  localparam logic [3:0] OP_TICK         = 4'd10;

  localparam logic REG_PULSE_DURATION = 1'b0;
  localparam logic REG_BLINK_PERIOD   = 1'b1;

  typedef struct packed {
    logic              load;
    logic              simple;
    logic              claim_pulse;
    logic              claim_blink;
    logic              blink_off;
    logic              blink_clear;
    logic              expire;
    logic              reload;
    logic              flip;
    logic              load_out;
    logic [SLOT_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic [3:0] op;
    logic       in_range;
    logic       pulse_free;
    logic       blink_free;
    logic       blink_fire;
  } sts_t;

  function automatic logic [63:0] led_mask(input logic [5:0] led);
    logic [63:0] m;
    m = '0;
    if ({1'b0, led} < 7'(NUM_LEDS)) begin
      m = 64'd1 << led;
    end
    return m;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/lopbc_in_if.sv =====
`default_nettype none
interface lopbc_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  op;
  logic [5:0]  led_index;
  logic        bit_value;
  logic [15:0] now;

  modport source (output valid, op, led_index, bit_value, now, input ready);
  modport sink (input valid, op, led_index, bit_value, now, output ready);
endinterface
`default_nettype wire

// ===== rtl/lopbc_out_if.sv =====
`default_nettype none
interface lopbc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] led_vector;
  logic [7:0]  pulse_busy;
  logic [3:0]  blink_busy;

  modport source (output valid, led_vector, pulse_busy, blink_busy, input ready);
  modport sink (input valid, led_vector, pulse_busy, blink_busy, output ready);
endinterface
`default_nettype wire

// ===== rtl/lopbc_ctrl.sv =====
`default_nettype none
`include "led_overlay_pulse_blink_controller_assert.svh"
module lopbc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire lopbc_pkg::sts_t sts,
  output lopbc_pkg::cmd_t    cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_PULSE  = 4'd2;
  localparam logic [3:0] S_BON    = 4'd3;
  localparam logic [3:0] S_BOFF   = 4'd4;
  localparam logic [3:0] S_BCLR   = 4'd5;
  localparam logic [3:0] S_EXPIRE = 4'd6;
  localparam logic [3:0] S_BCHK   = 4'd7;
  localparam logic [3:0] S_BFLIP  = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  localparam logic [lopbc_pkg::SLOT_W-1:0] PULSE_LAST =
    lopbc_pkg::SLOT_W'(lopbc_pkg::PULSE_SLOTS - 1);
  localparam logic [lopbc_pkg::SLOT_W-1:0] BLINK_LAST =
    lopbc_pkg::SLOT_W'(lopbc_pkg::BLINK_SLOTS - 1);

  logic [3:0]                   state_r, state_nxt;
  logic [lopbc_pkg::SLOT_W-1:0] idx_r, idx_nxt;
  logic                         out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    cmd.idx   = idx_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        idx_nxt = '0;
        if (!sts.in_range && (sts.op <= lopbc_pkg::OP_BLINK_OFF)) begin
          state_nxt = S_DONE;
        end else begin
          case (sts.op)
            lopbc_pkg::OP_SET, lopbc_pkg::OP_SET_TEMP, lopbc_pkg::OP_TOGGLE,
            lopbc_pkg::OP_TOGGLE_TEMP, lopbc_pkg::OP_RESTORE,
            lopbc_pkg::OP_CLEAR_ALL: begin
              cmd.simple = 1'b1;
              state_nxt  = S_DONE;
            end
            lopbc_pkg::OP_PULSE:        state_nxt = S_PULSE;
            lopbc_pkg::OP_BLINK_ON:     state_nxt = S_BON;
            lopbc_pkg::OP_BLINK_OFF:    state_nxt = S_BOFF;
            lopbc_pkg::OP_CLEAR_BLINKS: state_nxt = S_BCLR;
            lopbc_pkg::OP_TICK:         state_nxt = S_EXPIRE;
            default:                    state_nxt = S_DONE;
          endcase
        end
      end
      S_PULSE: begin
        if (sts.pulse_free) begin
          cmd.claim_pulse = 1'b1;
          state_nxt       = S_DONE;
        end else if (idx_r == PULSE_LAST) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt = idx_r + lopbc_pkg::SLOT_W'(1);
        end
      end
      S_BON: begin
        if (sts.blink_free) begin
          cmd.claim_blink = 1'b1;
          state_nxt       = S_DONE;
        end else if (idx_r == BLINK_LAST) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt = idx_r + lopbc_pkg::SLOT_W'(1);
        end
      end
      S_BOFF: begin
        cmd.blink_off = 1'b1;
        if (idx_r == BLINK_LAST) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt = idx_r + lopbc_pkg::SLOT_W'(1);
        end
      end
      S_BCLR: begin
        cmd.blink_clear = 1'b1;
        if (idx_r == BLINK_LAST) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt = idx_r + lopbc_pkg::SLOT_W'(1);
        end
      end
      S_EXPIRE: begin
        cmd.expire = 1'b1;
        if (idx_r == PULSE_LAST) begin
          state_nxt = S_BCHK;
        end else begin
          idx_nxt = idx_r + lopbc_pkg::SLOT_W'(1);
        end
      end
      S_BCHK: begin
        idx_nxt = '0;
        if (sts.blink_fire) begin
          cmd.reload = 1'b1;
          state_nxt  = S_BFLIP;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_BFLIP: begin
        cmd.flip = 1'b1;
        if (idx_r == BLINK_LAST) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt = idx_r + lopbc_pkg::SLOT_W'(1);
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = cmd.load_out | (out_valid_r & ~out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `LOPBC_ASSERT(a_busy_after_accept, (in_valid && in_ready) |=> !in_ready)
  `LOPBC_ASSERT(a_load_into_free_slot, cmd.load_out |-> (!out_valid_r || out_ready))
  `LOPBC_ASSERT(a_idx_in_range, idx_r <= PULSE_LAST || idx_r <= BLINK_LAST)
  `LOPBC_ASSERT_RST(a_no_result_after_reset, !rst_n |=> !out_valid)

endmodule
`default_nettype wire

// ===== rtl/lopbc_dpath.sv =====
`default_nettype none
module lopbc_dpath (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_we,
  input  wire logic            cfg_index,
  input  wire logic [15:0]     cfg_data,
  input  wire logic [3:0]      in_op,
  input  wire logic [5:0]      in_led_index,
  input  wire logic            in_bit_value,
  input  wire logic [15:0]     in_now,
  input  wire lopbc_pkg::cmd_t cmd,
  output lopbc_pkg::sts_t      sts,
  output logic [63:0]          out_led_vector,
  output logic [7:0]           out_pulse_busy,
  output logic [3:0]           out_blink_busy
);

  logic [15:0] duration_r;
  logic [14:0] period_r;

  logic [3:0]  op_r;
  logic [5:0]  led_r;
  logic        bit_r;
  logic [15:0] now_r;

  logic [63:0] shown_r, shown_nxt;
  logic [63:0] base_r, base_nxt;
  logic [5:0]  pled_r [lopbc_pkg::PULSE_SLOTS];
  logic [15:0] pend_r [lopbc_pkg::PULSE_SLOTS];
  logic [lopbc_pkg::PULSE_SLOTS-1:0] pact_r, pact_nxt;
  logic [5:0]  bled_r [lopbc_pkg::BLINK_SLOTS];
  logic [lopbc_pkg::BLINK_SLOTS-1:0] bact_r, bact_nxt;
  logic [15:0] nbt_r;

  logic [63:0] out_led_r;
  logic [7:0]  out_pbusy_r;
  logic [3:0]  out_bbusy_r;

  logic [lopbc_pkg::PIDX_W-1:0] pi;
  logic [lopbc_pkg::BIDX_W-1:0] bi;
  logic [63:0] m, pm, bm, nv;
  logic [15:0] diff;

  assign pi   = cmd.idx[lopbc_pkg::PIDX_W-1:0];
  assign bi   = cmd.idx[lopbc_pkg::BIDX_W-1:0];
  assign m    = lopbc_pkg::led_mask(led_r);
  assign pm   = lopbc_pkg::led_mask(pled_r[pi]);
  assign bm   = lopbc_pkg::led_mask(bled_r[bi]);
  assign nv   = (shown_r & m) ^ m;
  assign diff = nbt_r - now_r;

  assign sts.op         = op_r;
  assign sts.in_range   = ({1'b0, led_r} < 7'(lopbc_pkg::NUM_LEDS));
  assign sts.pulse_free = ~pact_r[pi];
  assign sts.blink_free = ~bact_r[bi];
  assign sts.blink_fire = (now_r > nbt_r) || (diff > {period_r, 1'b0});

  always_comb begin
    shown_nxt = shown_r;
    base_nxt  = base_r;
    pact_nxt  = pact_r;
    bact_nxt  = bact_r;
    if (cmd.simple) begin
      case (op_r)
        lopbc_pkg::OP_SET: begin
          shown_nxt = (shown_r & ~m) | (bit_r ? m : '0);
          base_nxt  = (base_r & ~m) | (bit_r ? m : '0);
        end
        lopbc_pkg::OP_SET_TEMP: begin
          shown_nxt = (shown_r & ~m) | (bit_r ? m : '0);
        end
        lopbc_pkg::OP_TOGGLE: begin
          shown_nxt = (shown_r & ~m) | nv;
          base_nxt  = (base_r & ~m) | nv;
        end
        lopbc_pkg::OP_TOGGLE_TEMP: begin
          shown_nxt = shown_r ^ m;
        end
        lopbc_pkg::OP_RESTORE: begin
          shown_nxt = (shown_r & ~m) | (base_r & m);
        end
        lopbc_pkg::OP_CLEAR_ALL: begin
          shown_nxt = '0;
          base_nxt  = '0;
        end
        default: begin
          shown_nxt = shown_r;
        end
      endcase
    end
    if (cmd.claim_pulse) begin
      pact_nxt[pi] = 1'b1;
      shown_nxt    = shown_r ^ m;
    end
    if (cmd.claim_blink) begin
      bact_nxt[bi] = 1'b1;
      shown_nxt    = shown_r ^ m;
    end
    if (cmd.blink_off && (bled_r[bi] == led_r)) begin
      bact_nxt[bi] = 1'b0;
      shown_nxt    = (shown_r & ~m) | (base_r & m);
    end
    if (cmd.blink_clear) begin
      bact_nxt[bi] = 1'b0;
      shown_nxt    = (shown_r & ~bm) | (base_r & bm);
    end
    if (cmd.expire && pact_r[pi] && (now_r > pend_r[pi])) begin
      pact_nxt[pi] = 1'b0;
      shown_nxt    = (shown_r & ~pm) | (base_r & pm);
    end
    if (cmd.flip && bact_r[bi]) begin
      shown_nxt = shown_r ^ bm;
    end
    shown_nxt = shown_nxt & lopbc_pkg::LED_ALL;
    base_nxt  = base_nxt & lopbc_pkg::LED_ALL;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duration_r <= 16'd3;
      period_r   <= 15'd15;
      shown_r    <= '0;
      base_r     <= '0;
      pact_r     <= '0;
      bact_r     <= '0;
      nbt_r      <= '0;
      for (int i = 0; i < lopbc_pkg::BLINK_SLOTS; i++) begin
        bled_r[i] <= '0;
      end
    end else begin
      if (cfg_we && (cfg_index == lopbc_pkg::REG_PULSE_DURATION)) begin
        duration_r <= cfg_data;
      end
      if (cfg_we && (cfg_index == lopbc_pkg::REG_BLINK_PERIOD)) begin
        period_r <= cfg_data[14:0];
      end
      shown_r <= shown_nxt;
      base_r  <= base_nxt;
      pact_r  <= pact_nxt;
      bact_r  <= bact_nxt;
      if (cmd.reload) begin
        nbt_r <= now_r + {1'b0, period_r};
      end
      if (cmd.claim_blink) begin
        bled_r[bi] <= led_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_op;
      led_r <= in_led_index;
      bit_r <= in_bit_value;
      now_r <= in_now;
    end
    if (cmd.claim_pulse) begin
      pled_r[pi] <= led_r;
      pend_r[pi] <= now_r + duration_r;
    end
    if (cmd.load_out) begin
      out_led_r   <= shown_r;
      out_pbusy_r <= 8'(pact_r);
      out_bbusy_r <= 4'(bact_r);
    end
  end

  assign out_led_vector = out_led_r;
  assign out_pulse_busy = out_pbusy_r;
  assign out_blink_busy = out_bbusy_r;

endmodule
`default_nettype wire

// ===== rtl/led_overlay_pulse_blink_controller.sv =====
// LED overlay controller with pulse and blink slots.
// Items arrive on in_ch (valid/ready) and carry an operation code, an LED index,
// a bit value and the current tick count. Each item gives exactly one result on
// out_ch: the displayed LED vector and the busy masks of the pulse and blink slots.
// Registers are written through cfg_we, cfg_index and cfg_data; the user must do so
// only while the block idles, as the block does not enforce it. Items are handled
// one at a time by a sequencer that walks the slots one per cycle. Plain writes go
// from decode to the result; a pulse or blink on walks its slots to the first free
// one, blink off and clear visit every blink slot, and a tick checks the eight pulse
// slots, then the blink timer, and when it fires flips the four blink slots. The next
// item is taken in the cycle after the result is loaded into the output register.
// The output register holds one result; while the receiver stalls, the block may
// finish the next item and then waits with it until the register frees up.
// A synchronous active-low reset clears both LED layers, the slot masks, the blink
// timer and the blink slot LEDs, and restores the register defaults.
`default_nettype none
module led_overlay_pulse_blink_controller (
  input  wire logic    clk,
  input  wire logic    rst_n,
  lopbc_in_if.sink     in_ch,
  lopbc_out_if.source  out_ch,
  input  wire logic    cfg_we,
  input  wire logic    cfg_index,
  input  wire logic [15:0] cfg_data
);

  lopbc_pkg::cmd_t cmd;
  lopbc_pkg::sts_t sts;

  lopbc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lopbc_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_op          (in_ch.op),
    .in_led_index   (in_ch.led_index),
    .in_bit_value   (in_ch.bit_value),
    .in_now         (in_ch.now),
    .cmd            (cmd),
    .sts            (sts),
    .out_led_vector (out_ch.led_vector),
    .out_pulse_busy (out_ch.pulse_busy),
    .out_blink_busy (out_ch.blink_busy)
  );

endmodule
`default_nettype wire

// ===== sim/lopbc_checker.sv =====
`timescale 1ns / 1ps
module lopbc_checker (
  input  logic        clk,
  input  logic        rst_n,
  lopbc_in_if         in_ch,
  lopbc_out_if        out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic [63:0] leds;
    logic [7:0]  pulses;
    logic [3:0]  blinks;
  } panel_state_t;

  panel_state_t panel_q[$];
  panel_state_t want;

  logic [63:0]                       shown_q;
  logic [63:0]                       base_q;
  logic [5:0]                        pulse_led [lopbc_pkg::PULSE_SLOTS];
  logic [15:0]                       pulse_end [lopbc_pkg::PULSE_SLOTS];
  logic [lopbc_pkg::PULSE_SLOTS-1:0] pulse_on;
  logic [5:0]                        blink_led [lopbc_pkg::BLINK_SLOTS];
  logic [lopbc_pkg::BLINK_SLOTS-1:0] blink_on;
  logic [15:0]                       blink_due;
  logic [15:0]                       pulse_len;
  logic [14:0]                       blink_len;
  int                                fail_count = 0;

  function automatic logic [63:0] bit_of(input logic [5:0] led);
    return (int'(led) < lopbc_pkg::NUM_LEDS) ? (64'd1 << led) : 64'd0;
  endfunction

  task automatic revert_led(input logic [5:0] led);
    logic [63:0] m;
    m = bit_of(led);
    shown_q = (shown_q & ~m) | (base_q & m);
  endtask

  task automatic apply_item(input logic [3:0] op, input logic [5:0] led, input logic v,
                            input logic [15:0] now);
    logic [63:0] m;
    logic [63:0] nv;
    logic [15:0] due;
    logic        done;
    logic        skip;
    m = bit_of(led);
    done = 1'b0;
    skip = (op <= lopbc_pkg::OP_BLINK_OFF) && (int'(led) >= lopbc_pkg::NUM_LEDS);
    if (!skip) begin
      case (op)
        lopbc_pkg::OP_SET: begin
          shown_q = (shown_q & ~m) | (v ? m : 64'd0);
          base_q = (base_q & ~m) | (v ? m : 64'd0);
        end
        lopbc_pkg::OP_SET_TEMP: shown_q = (shown_q & ~m) | (v ? m : 64'd0);
        lopbc_pkg::OP_TOGGLE: begin
          nv = (shown_q & m) ^ m;
          shown_q = (shown_q & ~m) | nv;
          base_q = (base_q & ~m) | nv;
        end
        lopbc_pkg::OP_TOGGLE_TEMP: shown_q = shown_q ^ m;
        lopbc_pkg::OP_RESTORE: revert_led(led);
        lopbc_pkg::OP_PULSE: begin
          for (int i = 0; i < lopbc_pkg::PULSE_SLOTS; i++) begin
            if (!done && !pulse_on[i]) begin
              pulse_led[i] = led;
              pulse_on[i] = 1'b1;
              pulse_end[i] = now + pulse_len;
              shown_q = shown_q ^ m;
              done = 1'b1;
            end
          end
        end
        lopbc_pkg::OP_BLINK_ON: begin
          for (int i = 0; i < lopbc_pkg::BLINK_SLOTS; i++) begin
            if (!done && !blink_on[i]) begin
              blink_led[i] = led;
              blink_on[i] = 1'b1;
              shown_q = shown_q ^ m;
              done = 1'b1;
            end
          end
        end
        lopbc_pkg::OP_BLINK_OFF: begin
          for (int i = 0; i < lopbc_pkg::BLINK_SLOTS; i++) begin
            if (blink_led[i] == led) begin
              blink_on[i] = 1'b0;
              revert_led(led);
            end
          end
        end
        lopbc_pkg::OP_CLEAR_BLINKS: begin
          for (int i = 0; i < lopbc_pkg::BLINK_SLOTS; i++) begin
            revert_led(blink_led[i]);
            blink_on[i] = 1'b0;
          end
        end
        lopbc_pkg::OP_CLEAR_ALL: begin
          shown_q = '0;
          base_q = '0;
        end
        lopbc_pkg::OP_TICK: begin
          due = blink_due;
          for (int i = 0; i < lopbc_pkg::PULSE_SLOTS; i++) begin
            if (pulse_on[i] && now > pulse_end[i]) begin
              pulse_on[i] = 1'b0;
              revert_led(pulse_led[i]);
            end
          end
          // The timer also fires when it lies too far ahead, which catches a wrap of now.
          if (now > due || (int'(due) - int'(now)) > 2 * int'(blink_len)) begin
            blink_due = now + blink_len;
            for (int i = 0; i < lopbc_pkg::BLINK_SLOTS; i++) begin
              if (blink_on[i]) shown_q = shown_q ^ bit_of(blink_led[i]);
            end
          end
        end
        default: ;
      endcase
    end
    shown_q = shown_q & lopbc_pkg::LED_ALL;
    base_q = base_q & lopbc_pkg::LED_ALL;
  endtask

  task automatic report(input string what, input panel_state_t exp_s);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t: %s: expected leds %h pulses %h blinks %h, got leds %h pulses %h blinks %h",
               $realtime, what, exp_s.leds, exp_s.pulses, exp_s.blinks,
               out_ch.led_vector, out_ch.pulse_busy, out_ch.blink_busy);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      shown_q = '0;
      base_q = '0;
      pulse_on = '0;
      blink_on = '0;
      blink_due = '0;
      pulse_len = 16'd3;
      blink_len = 15'd15;
      for (int i = 0; i < lopbc_pkg::PULSE_SLOTS; i++) begin
        pulse_led[i] = '0;
        pulse_end[i] = '0;
      end
      for (int i = 0; i < lopbc_pkg::BLINK_SLOTS; i++) blink_led[i] = '0;
      panel_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == lopbc_pkg::REG_PULSE_DURATION) pulse_len = cfg_data;
        else blink_len = cfg_data[14:0];
      end
      if (in_ch.valid && in_ch.ready) begin
        apply_item(in_ch.op, in_ch.led_index, in_ch.bit_value, in_ch.now);
        want.leds = shown_q;
        want.pulses = 8'(pulse_on);
        want.blinks = 4'(blink_on);
        panel_q.push_back(want);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (panel_q.size() == 0) begin
          report("result with no item outstanding", '0);
        end else begin
          want = panel_q.pop_front();
          if (want.leds !== out_ch.led_vector || want.pulses !== out_ch.pulse_busy ||
              want.blinks !== out_ch.blink_busy) begin
            report("mismatch", want);
          end
        end
      end
    end
    errors <= fail_count;
    pending <= panel_q.size();
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
module tb;

  localparam logic [3:0] OP_SPARE_FIRST = 4'd11;
  localparam logic [3:0] OP_SPARE_LAST  = 4'd15;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASES       = 5;
  localparam int PHASE_ITEMS  = 150;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;
  int          errors;
  int          pending;
  int          burst_left;
  logic [15:0] tick_now;
  int          rx_cycle = 0;
  int          rx_hold = 0;

  lopbc_in_if  in_ch ();
  lopbc_out_if out_ch ();

  led_overlay_pulse_blink_controller dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lopbc_checker led_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  always #1 clk = ~clk;

  // The receiver steps through four stall patterns in turn and now and then holds off
  // long enough for the block to fill up and refuse further items.
  always @(posedge clk) begin
    rx_cycle = rx_cycle + 1;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (rx_hold > 0) begin
      out_ch.ready <= 1'b0;
      rx_hold = rx_hold - 1;
    end else if (rx_cycle % 1500 == 700) begin
      out_ch.ready <= 1'b0;
      rx_hold = 60;
    end else begin
      case ((rx_cycle / 200) % 4)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= 1'($urandom_range(0, 1));
        2: out_ch.ready <= ($urandom_range(0, 7) != 0);
        default: out_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic offer(input logic [3:0] op, input logic [5:0] led, input logic v,
                       input logic [15:0] now);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.led_index <= led;
    in_ch.bit_value <= v;
    in_ch.now <= now;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
    if (burst_left <= 0) begin
      gap = $urandom_range(0, 8);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic random_item();
    int          r;
    logic [3:0]  op;
    logic [5:0]  led;
    r = $urandom_range(0, 99);
    if (r < 85) tick_now = tick_now + 16'($urandom_range(0, 3));
    else if (r < 95) tick_now = tick_now + 16'($urandom_range(4, 60));
    else tick_now = 16'($urandom);
    r = $urandom_range(0, 99);
    if (r < 10) op = lopbc_pkg::OP_SET;
    else if (r < 18) op = lopbc_pkg::OP_SET_TEMP;
    else if (r < 26) op = lopbc_pkg::OP_TOGGLE;
    else if (r < 32) op = lopbc_pkg::OP_TOGGLE_TEMP;
    else if (r < 38) op = lopbc_pkg::OP_RESTORE;
    else if (r < 50) op = lopbc_pkg::OP_PULSE;
    else if (r < 58) op = lopbc_pkg::OP_BLINK_ON;
    else if (r < 64) op = lopbc_pkg::OP_BLINK_OFF;
    else if (r < 67) op = lopbc_pkg::OP_CLEAR_BLINKS;
    else if (r < 69) op = lopbc_pkg::OP_CLEAR_ALL;
    else if (r < 97) op = lopbc_pkg::OP_TICK;
    else op = 4'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
    // Mostly a small group of LEDs, so that slots, layers and blink matches interact.
    if ($urandom_range(0, 3) == 0) led = 6'($urandom_range(0, 63));
    else led = 6'($urandom_range(0, 7));
    offer(op, led, 1'($urandom_range(0, 1)), tick_now);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_regs(input logic [15:0] duration, input logic [15:0] period);
    cfg_we <= 1'b1;
    cfg_index <= lopbc_pkg::REG_PULSE_DURATION;
    cfg_data <= duration;
    @(posedge clk);
    cfg_index <= lopbc_pkg::REG_BLINK_PERIOD;
    cfg_data <= period;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.op = lopbc_pkg::OP_SET;
    in_ch.led_index = '0;
    in_ch.bit_value = 1'b0;
    in_ch.now = '0;
    out_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = lopbc_pkg::REG_PULSE_DURATION;
    cfg_data = '0;
    rst_n = 1'b0;
    burst_left = 8;
    tick_now = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    offer(lopbc_pkg::OP_SET, 6'd0, 1'b1, 16'd0);
    offer(lopbc_pkg::OP_SET, 6'd63, 1'b1, 16'd0);
    offer(lopbc_pkg::OP_SET_TEMP, 6'd0, 1'b0, 16'd0);
    // Blink off before any blink on matches the idle slots, which all hold LED 0.
    offer(lopbc_pkg::OP_BLINK_OFF, 6'd0, 1'b0, 16'd0);
    offer(lopbc_pkg::OP_TOGGLE, 6'd5, 1'b0, 16'd0);
    offer(lopbc_pkg::OP_TOGGLE_TEMP, 6'd5, 1'b0, 16'd0);
    offer(lopbc_pkg::OP_RESTORE, 6'd5, 1'b0, 16'd0);
    // Nine pulses for eight slots, ending past the wrap of the tick count.
    for (int i = 0; i < 9; i++) offer(lopbc_pkg::OP_PULSE, 6'(10 + i), 1'b0, 16'hFFFE);
    for (int i = 0; i < 5; i++) offer(lopbc_pkg::OP_BLINK_ON, 6'(20 + i), 1'b0, 16'd0);
    offer(lopbc_pkg::OP_BLINK_OFF, 6'd22, 1'b0, 16'd0);
    offer(lopbc_pkg::OP_BLINK_OFF, 6'd22, 1'b0, 16'd0);
    offer(lopbc_pkg::OP_TICK, 6'd0, 1'b0, 16'd200);
    offer(lopbc_pkg::OP_TICK, 6'd0, 1'b0, 16'd100);
    offer(lopbc_pkg::OP_TICK, 6'd63, 1'b1, 16'hFFFF);
    offer(lopbc_pkg::OP_CLEAR_BLINKS, 6'd0, 1'b0, 16'd0);
    offer(lopbc_pkg::OP_CLEAR_ALL, 6'd0, 1'b0, 16'd0);
    offer(OP_SPARE_LAST, 6'd63, 1'b1, 16'hFFFF);

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        settle();
        case (phase)
          1: write_regs(16'd0, 16'd1);
          2: write_regs(16'hFFFF, 16'h7FFF);
          3: write_regs(16'($urandom_range(1, 12)), 16'($urandom_range(1, 40)));
          default: write_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(1, 32767)));
        endcase
      end
      repeat (PHASE_ITEMS) random_item();
    end

    settle();
    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
